// ----- rtl/dsce_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Digraph square cipher encoder package
// Shared widths, register indexes and the types that travel between modules.
// ----------------------------------------------------------------------------
package dsce_pkg;

    localparam int CHAR_W     = 8;
    localparam int SQ_N       = 5;
    localparam int CFG_W      = 40;
    localparam int CFG_ADDR_W = 3;
    localparam int IDX_W      = 3;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CHAR_W-1:0] char_t;

    // Highest row or column index; the next index after it wraps to zero.
    localparam idx_t SQ_LAST = 3'd4;

    // Filler letter after reset ('X').
    localparam char_t FILLER_RESET = 8'd88;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ROW0   = 3'd0,
        REG_ROW1   = 3'd1,
        REG_ROW2   = 3'd2,
        REG_ROW3   = 3'd3,
        REG_ROW4   = 3'd4,
        REG_FILLER = 3'd5
    } cfg_reg_e;

    // Key square: square[row][col], column 0 in the low byte of each row.
    typedef logic [SQ_N-1:0][SQ_N-1:0][CHAR_W-1:0] square_t;

    // One letter pair waiting to be enciphered.
    typedef struct packed {
        char_t a;
        char_t b;
        logic  last;    // second letter closes the run of its input word
    } pair_t;

    // Head of the pair queue as seen by the encipher stage.
    typedef struct packed {
        logic  valid;
        pair_t pair;
    } pair_head_t;

endpackage : dsce_pkg
`default_nettype wire

// ----- rtl/dsce_pair.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Digraph square cipher pairing stage
// Groups plaintext words into letter pairs and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module dsce_pair
    import dsce_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire char_t      filler,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire char_t      in_char,
    input  wire logic       in_last,
    output pair_head_t      head,
    input  wire logic       pop
);

    char_t       pend_char_reg, pend_char_next;
    logic        pend_valid_reg, pend_valid_next;
    pair_t       slot0_reg, slot0_next;
    pair_t       slot1_reg, slot1_next;
    logic [1:0]  cnt_reg, cnt_next;

    logic        accept;
    logic        push_one;
    logic        push_two;
    pair_t       first_pair;
    pair_t       second_pair;

    // New words are taken only when the queue is empty once the head leaves.
    assign in_ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);
    assign accept   = in_valid && in_ready;

    assign head.valid = (cnt_reg != 2'd0);
    assign head.pair  = slot0_reg;

    // Pairing decisions for the incoming word.
    always_comb
    begin
        pend_char_next  = pend_char_reg;
        pend_valid_next = pend_valid_reg;
        push_one        = 1'b0;
        push_two        = 1'b0;
        first_pair      = '{a: in_char, b: filler, last: 1'b1};
        second_pair     = '{a: in_char, b: filler, last: 1'b1};
        if (accept)
        begin
            if (!pend_valid_reg)
            begin
                if (in_last)
                begin
                    push_one = 1'b1;
                end
                else
                begin
                    pend_char_next  = in_char;
                    pend_valid_next = 1'b1;
                end
            end
            else if (in_char == pend_char_reg)
            begin
                // Doubled letter: close the open pair with the filler.
                push_one   = 1'b1;
                first_pair = '{a: pend_char_reg, b: filler, last: !in_last};
                if (in_last)
                begin
                    push_two        = 1'b1;
                    pend_valid_next = 1'b0;
                    pend_char_next  = '0;
                end
                else
                begin
                    pend_char_next = in_char;
                end
            end
            else
            begin
                push_one        = 1'b1;
                first_pair      = '{a: pend_char_reg, b: in_char, last: 1'b1};
                pend_valid_next = 1'b0;
                pend_char_next  = '0;
            end
        end
    end

    // Queue update: pop shifts the tail forward, pushes land at the front.
    always_comb
    begin
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        cnt_next   = cnt_reg;
        if (pop && head.valid)
        begin
            slot0_next = slot1_reg;
            cnt_next   = cnt_reg - 2'd1;
        end
        if (push_one)
        begin
            slot0_next = first_pair;
            cnt_next   = push_two ? 2'd2 : 2'd1;
        end
        if (push_two)
        begin
            slot1_next = second_pair;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_char_reg  <= '0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= 2'd0;
        end
        else
        begin
            pend_char_reg  <= pend_char_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule : dsce_pair
`default_nettype wire

// ----- rtl/dsce_encode.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Digraph square cipher encipher stage
// Looks up both letters of a pair, applies the square rules and sends the two
// cipher letters from a result register, one per cycle while out_ready holds.
// ----------------------------------------------------------------------------
module dsce_encode
    import dsce_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire square_t     square,
    input  wire pair_head_t  head,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output char_t            out_char,
    output logic             out_last,
    output logic             out_flag
);

    typedef struct packed {
        logic found;
        idx_t row;
        idx_t col;
    } loc_t;

    // First match in row-major order wins.
    function automatic loc_t locate(input char_t ch, input square_t sq);
        loc_t res;
        res = '{found: 1'b0, row: '0, col: '0};
        for (int r = SQ_N - 1; r >= 0; r--)
        begin
            for (int c = SQ_N - 1; c >= 0; c--)
            begin
                if (sq[r][c] == ch)
                begin
                    res = '{found: 1'b1, row: IDX_W'(r), col: IDX_W'(c)};
                end
            end
        end
        return res;
    endfunction

    function automatic idx_t next_idx(input idx_t i);
        return (i >= SQ_LAST) ? '0 : i + idx_t'(1);
    endfunction

    logic   res_valid_reg, res_valid_next;
    logic   sel_reg, sel_next;
    char_t  x_reg, x_next;
    char_t  y_reg, y_next;
    logic   flag_reg, flag_next;
    logic   last_reg, last_next;

    loc_t   loc_a;
    loc_t   loc_b;
    char_t  enc_x;
    char_t  enc_y;
    logic   enc_flag;
    logic   take;

    // Square rules for the pair at the head of the queue.
    always_comb
    begin
        loc_a    = locate(head.pair.a, square);
        loc_b    = locate(head.pair.b, square);
        enc_flag = 1'b0;
        if (!loc_a.found || !loc_b.found)
        begin
            enc_x    = '0;
            enc_y    = '0;
            enc_flag = 1'b1;
        end
        else if ((loc_a.row != loc_b.row) && (loc_a.col != loc_b.col))
        begin
            enc_x = square[loc_a.row][loc_b.col];
            enc_y = square[loc_b.row][loc_a.col];
        end
        else if (loc_a.row == loc_b.row)
        begin
            enc_x = square[loc_a.row][next_idx(loc_a.col)];
            enc_y = square[loc_b.row][next_idx(loc_b.col)];
        end
        else
        begin
            enc_x = square[next_idx(loc_a.row)][loc_a.col];
            enc_y = square[next_idx(loc_b.row)][loc_b.col];
        end
    end

    assign take = res_valid_reg && out_ready;
    assign pop  = head.valid && (!res_valid_reg || (sel_reg && out_ready));

    // Result register: first letter, then second, then reload.
    always_comb
    begin
        res_valid_next = res_valid_reg;
        sel_next       = sel_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        flag_next      = flag_reg;
        last_next      = last_reg;
        if (take)
        begin
            if (!sel_reg)
            begin
                sel_next = 1'b1;
            end
            else
            begin
                res_valid_next = 1'b0;
            end
        end
        if (pop)
        begin
            res_valid_next = 1'b1;
            sel_next       = 1'b0;
            x_next         = enc_x;
            y_next         = enc_y;
            flag_next      = enc_flag;
            last_next      = head.pair.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            sel_reg       <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            sel_reg       <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        flag_reg <= flag_next;
        last_reg <= last_next;
    end

    assign out_valid = res_valid_reg;
    assign out_char  = sel_reg ? y_reg : x_reg;
    assign out_last  = sel_reg && last_reg;
    assign out_flag  = flag_reg;

endmodule : dsce_encode
`default_nettype wire

// ----- rtl/digraph_square_cipher_encoder_core.sv -----
`default_nettype none
// A word that completes a pair is registered in the pair queue, then in the
// result register, before its first cipher letter shows on m_tvalid; the
// second letter follows once the first is taken. Throughput: one cipher letter
// per cycle while m_tready is high, set by the single output register.
// Reset: asynchronous, active low; clears the open pair, the queues, the square
// (all zero) and sets the filler letter to 'X'.
// ----------------------------------------------------------------------------
// Digraph square cipher encoder core
// Pairs plaintext letters and enciphers each pair with a 5x5 key square.
// ----------------------------------------------------------------------------
module digraph_square_cipher_encoder_core
    import dsce_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_wdata,
    // Plaintext stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [7:0]             s_tdata,    // [7:0] char_in
    input  wire logic                   s_tlast,    // last_char
    // Cipher stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,    // [7:0] cipher_char
    output logic                        m_tlast,    // run_end
    output logic                        m_tuser     // [0] not_in_square
);

    square_t     square_reg;
    char_t       filler_reg;
    pair_head_t  head;
    logic        pop;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_reg <= '0;
            filler_reg <= FILLER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_ROW0:   square_reg[0] <= cfg_wdata;
                REG_ROW1:   square_reg[1] <= cfg_wdata;
                REG_ROW2:   square_reg[2] <= cfg_wdata;
                REG_ROW3:   square_reg[3] <= cfg_wdata;
                REG_ROW4:   square_reg[4] <= cfg_wdata;
                REG_FILLER: filler_reg    <= cfg_wdata[CHAR_W-1:0];
                default:    ;
            endcase
        end
    end

    // Pairing and pair queue.
    dsce_pair u_pair (
        .clk      (clk),
        .rst_n    (rst_n),
        .filler   (filler_reg),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_char  (s_tdata),
        .in_last  (s_tlast),
        .head     (head),
        .pop      (pop)
    );

    // Square lookup and output register.
    dsce_encode u_encode (
        .clk       (clk),
        .rst_n     (rst_n),
        .square    (square_reg),
        .head      (head),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_flag  (m_tuser)
    );

endmodule : digraph_square_cipher_encoder_core
`default_nettype wire

// ----- rtl/dsce_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Digraph square cipher encoder checker
// Port-level checks on the cipher stream, bound to the core.
// ----------------------------------------------------------------------------
module dsce_checker
    import dsce_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [7:0]  m_tdata,
    input wire logic        m_tlast,
    input wire logic        m_tuser
);

    // A stalled output word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("cipher word changed while stalled");

    // A flagged letter is always sent as zero.
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 8'd0)
        else $error("flagged cipher letter is not zero");

    // Inside a run the next letter is ready right after the previous one.
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a run of cipher letters");

    // Input is held off only while letters are on their way out.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> m_tvalid)
        else $error("input stalled with no output pending");

endmodule : dsce_checker

bind digraph_square_cipher_encoder_core dsce_checker u_dsce_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ----- test/digraph_square_cipher_encoder_core_test.sv -----
// ----------------------------------------------------------------------------
// Digraph square cipher encoder core testbench
// Drives plaintext words with random gaps and compares every cipher word
// against a letter-pair predictor kept in step with the key-square registers.
// A short directed table comes first. Random phases follow, each under a fresh
// key square, including a long receiver hold-off and a full sender drain.
// ----------------------------------------------------------------------------
module digraph_square_cipher_encoder_core_test;
    import dsce_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 8;
    localparam int PHASE_ITEMS  = 85;
    localparam int RANDOM_PHASES = 6;
    localparam int MAX_REPORTS  = 10;

    // Kinds of key square loaded in the random phases.
    typedef enum int {
        SQ_ALPHABET,
        SQ_FEW_LETTERS,
        SQ_ANY_BYTES
    } square_kind_e;

    // Kinds of row in the directed table.
    typedef enum int {
        ROW_ITEM,
        ROW_CFG
    } row_kind_e;

    typedef struct packed {
        char_t ch;
        logic  run_end;
        logic  absent;
    } cipher_word_t;

    typedef struct {
        row_kind_e        kind;
        cfg_reg_e         reg_sel;
        logic [CFG_W-1:0] value;
        char_t            ch;
        bit               last;
        bit               typed;
        int               typed_n;
        char_t            typed_x;
        char_t            typed_y;
        bit               typed_absent;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [7:0] char_in
    logic                  s_tlast;     // last_char
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;     // [7:0] cipher_char
    logic                  m_tlast;     // run_end
    logic                  m_tuser;     // [0] not_in_square

    // Predictor state: key square, filler letter and the open pair.
    square_t      key_sq;
    char_t        filler;
    char_t        open_char;
    bit           open_valid;
    cipher_word_t pair_words [4];
    int           pair_word_n;

    cipher_word_t cipher_q [$];
    cipher_word_t head_word;
    stim_row_t    stim_rows [$];

    bit steady;
    bit hold_req;
    int err_count;
    int words_checked;
    int items_sent;
    int settings_used;
    int stall_cycles;

    digraph_square_cipher_encoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // First match in row-major order, as the square may hold repeated letters.
    function automatic bit find_letter(input char_t ch, output idx_t r, output idx_t c);
        bit found;
        found = 1'b0;
        r = '0;
        c = '0;
        for (int i = 0; i < SQ_N; i++)
        begin
            for (int j = 0; j < SQ_N; j++)
            begin
                if (!found && key_sq[i][j] == ch)
                begin
                    found = 1'b1;
                    r = idx_t'(i);
                    c = idx_t'(j);
                end
            end
        end
        return found;
    endfunction

    function automatic idx_t wrap_next(input idx_t i);
        return (i >= SQ_LAST) ? '0 : idx_t'(i + 1);
    endfunction

    // Enciphers one letter pair into the next two predicted words.
    task automatic encipher_pair(input char_t a, input char_t b);
        idx_t  ra, ca, rb, cb;
        bit    fa, fb;
        char_t x, y;
        bit    absent;
        fa = find_letter(a, ra, ca);
        fb = find_letter(b, rb, cb);
        absent = 1'b0;
        if (!fa || !fb)
        begin
            x = '0;
            y = '0;
            absent = 1'b1;
        end
        else if (ra != rb && ca != cb)
        begin
            x = key_sq[ra][cb];
            y = key_sq[rb][ca];
        end
        else if (ra == rb)
        begin
            // Same row, which also covers a pair of identical letters.
            x = key_sq[ra][wrap_next(ca)];
            y = key_sq[rb][wrap_next(cb)];
        end
        else
        begin
            x = key_sq[wrap_next(ra)][ca];
            y = key_sq[wrap_next(rb)][cb];
        end
        pair_words[pair_word_n]     = '{ch: x, run_end: 1'b0, absent: absent};
        pair_words[pair_word_n + 1] = '{ch: y, run_end: 1'b0, absent: absent};
        pair_word_n += 2;
    endtask

    // Pairs one plaintext letter and predicts the cipher words it releases.
    task automatic predict_letter(input char_t ch, input bit last);
        pair_word_n = 0;
        if (!open_valid)
        begin
            if (last)
                encipher_pair(ch, filler);
            else
            begin
                open_char = ch;
                open_valid = 1'b1;
            end
        end
        else if (ch == open_char)
        begin
            // Doubled letter: the filler closes the open pair.
            encipher_pair(open_char, filler);
            if (last)
            begin
                encipher_pair(ch, filler);
                open_valid = 1'b0;
                open_char = '0;
            end
        end
        else
        begin
            encipher_pair(open_char, ch);
            open_valid = 1'b0;
            open_char = '0;
        end
        if (pair_word_n > 0)
            pair_words[pair_word_n - 1].run_end = 1'b1;
    endtask

    function automatic stim_row_t row_item(input char_t ch, input bit last);
        stim_row_t r;
        r.kind = ROW_ITEM;
        r.reg_sel = REG_ROW0;
        r.value = '0;
        r.ch = ch;
        r.last = last;
        r.typed = 1'b0;
        r.typed_n = 0;
        r.typed_x = '0;
        r.typed_y = '0;
        r.typed_absent = 1'b0;
        return r;
    endfunction

    function automatic stim_row_t row_typed(input char_t ch, input bit last, input int n,
                                            input char_t x, input char_t y, input bit absent);
        stim_row_t r;
        r = row_item(ch, last);
        r.typed = 1'b1;
        r.typed_n = n;
        r.typed_x = x;
        r.typed_y = y;
        r.typed_absent = absent;
        return r;
    endfunction

    function automatic stim_row_t row_cfg(input cfg_reg_e sel, input logic [CFG_W-1:0] v);
        stim_row_t r;
        r = row_item('0, 1'b0);
        r.kind = ROW_CFG;
        r.reg_sel = sel;
        r.value = v;
        return r;
    endfunction

    // Register write, mirrored into the predictor.
    task automatic write_reg(input cfg_reg_e sel, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_addr = sel;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we = 1'b0;
        if (sel == REG_FILLER)
            filler = v[CHAR_W-1:0];
        else
            key_sq[sel] = v;
    endtask

    // Stops offering words and waits until every predicted word has come out.
    task automatic drain_block(input int extra_cycles);
        @(negedge clk);
        s_tvalid = 1'b0;
        while (cipher_q.size() != 0)
            @(posedge clk);
        repeat (extra_cycles) @(posedge clk);
    endtask

    // Offers one plaintext word, then records what it is expected to release.
    task automatic send_row(input stim_row_t row);
        @(negedge clk);
        while (!steady && $urandom_range(99) < 11)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = row.ch;
        s_tlast = row.last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_letter(row.ch, row.last);
        if (row.typed)
        begin
            if (row.typed_n != 0)
            begin
                cipher_q.push_back('{ch: row.typed_x, run_end: 1'b0, absent: row.typed_absent});
                cipher_q.push_back('{ch: row.typed_y, run_end: 1'b1, absent: row.typed_absent});
            end
        end
        else
        begin
            for (int k = 0; k < pair_word_n; k++)
                cipher_q.push_back(pair_words[k]);
        end
        items_sent++;
    endtask

    // Loads a fresh key square and filler; used between random phases.
    task automatic load_square(input square_kind_e kind);
        char_t            letters [26];
        logic [CFG_W-1:0] row_val;
        char_t            tmp;
        int               j;
        for (int i = 0; i < 26; i++)
            letters[i] = char_t'(8'h41 + i);
        for (int i = 25; i > 0; i--)
        begin
            j = $urandom_range(i);
            tmp = letters[i];
            letters[i] = letters[j];
            letters[j] = tmp;
        end
        for (int r = 0; r < SQ_N; r++)
        begin
            for (int c = 0; c < SQ_N; c++)
            begin
                case (kind)
                    SQ_ALPHABET:    row_val[c*CHAR_W +: CHAR_W] = letters[r*SQ_N + c];
                    SQ_FEW_LETTERS: row_val[c*CHAR_W +: CHAR_W] = char_t'(8'h41 + $urandom_range(7));
                    default:        row_val[c*CHAR_W +: CHAR_W] = char_t'($urandom_range(255));
                endcase
            end
            write_reg(cfg_reg_e'(r), row_val);
        end
        // The filler is a square letter half the time, else an extreme or random code.
        case ($urandom_range(5))
            0:       tmp = 8'h00;
            1:       tmp = 8'hFF;
            2:       tmp = char_t'($urandom_range(255));
            default: tmp = key_sq[$urandom_range(SQ_N - 1)][$urandom_range(SQ_N - 1)];
        endcase
        write_reg(REG_FILLER, {{(CFG_W-CHAR_W){1'b0}}, tmp});
        settings_used++;
    endtask

    // Cipher word receiver and checker.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                // Long hold-off so the block fills up and stalls its input.
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            m_tready = steady ? 1'b1 : ($urandom_range(99) >= 11);
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (cipher_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("Unexpected cipher word: char %h end %b absent %b",
                                 m_tdata, m_tlast, m_tuser);
                end
                else
                begin
                    head_word = cipher_q.pop_front();
                    words_checked++;
                    if (m_tdata !== head_word.ch || m_tlast !== head_word.run_end ||
                        m_tuser !== head_word.absent)
                    begin
                        err_count++;
                        if (err_count <= MAX_REPORTS)
                            $display({"Cipher word mismatch: expected char %h end %b absent %b,",
                                      " got char %h end %b absent %b"},
                                     head_word.ch, head_word.run_end, head_word.absent,
                                     m_tdata, m_tlast, m_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves for too long.
    initial
    begin
        stall_cycles = 0;
        @(posedge rst_n);
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no word accepted for %0d cycles", STALL_LIMIT);
        $display("digraph_square_cipher_encoder_core verification failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        square_kind_e phase_kind [RANDOM_PHASES];
        stim_row_t    row;
        char_t        prev_char;
        char_t        ch;
        int           pick;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        steady = 1'b0;
        hold_req = 1'b0;
        err_count = 0;
        words_checked = 0;
        items_sent = 0;
        settings_used = 1;
        key_sq = '0;
        filler = FILLER_RESET;
        open_char = '0;
        open_valid = 1'b0;

        // After reset: all-zero square, filler 'X' absent from it.
        stim_rows.push_back(row_typed(8'h41, 1'b1, 2, 8'h00, 8'h00, 1'b1));
        stim_rows.push_back(row_typed(8'h00, 1'b0, 0, 8'h00, 8'h00, 1'b0));
        stim_rows.push_back(row_typed(8'h00, 1'b0, 2, 8'h00, 8'h00, 1'b1));
        stim_rows.push_back(row_typed(8'h7F, 1'b0, 2, 8'h00, 8'h00, 1'b1));
        stim_rows.push_back(row_typed(8'h00, 1'b1, 2, 8'h00, 8'h00, 1'b1));
        // Zero filler: a lone zero pairs with itself inside the square.
        stim_rows.push_back(row_cfg(REG_FILLER, 40'h00));
        stim_rows.push_back(row_typed(8'h00, 1'b1, 2, 8'h00, 8'h00, 1'b0));
        stim_rows.push_back(row_item(8'hFF, 1'b0));
        stim_rows.push_back(row_item(8'hFF, 1'b1));
        // Keyword square with every letter but J.
        stim_rows.push_back(row_cfg(REG_ROW0, 40'h46_59_41_4C_50));
        stim_rows.push_back(row_cfg(REG_ROW1, 40'h4D_58_45_52_49));
        stim_rows.push_back(row_cfg(REG_ROW2, 40'h48_47_44_43_42));
        stim_rows.push_back(row_cfg(REG_ROW3, 40'h53_51_4F_4E_4B));
        stim_rows.push_back(row_cfg(REG_ROW4, 40'h5A_57_56_55_54));
        stim_rows.push_back(row_cfg(REG_FILLER, 40'h58));
        stim_rows.push_back(row_item("H", 1'b0));   // rectangle
        stim_rows.push_back(row_item("I", 1'b0));
        stim_rows.push_back(row_item("P", 1'b0));   // same row, wraps right
        stim_rows.push_back(row_item("F", 1'b0));
        stim_rows.push_back(row_item("T", 1'b0));   // same column, wraps down
        stim_rows.push_back(row_item("P", 1'b0));
        stim_rows.push_back(row_item("J", 1'b0));   // letter absent
        stim_rows.push_back(row_item("A", 1'b0));
        stim_rows.push_back(row_item("E", 1'b0));   // doubled letter
        stim_rows.push_back(row_item("E", 1'b0));
        stim_rows.push_back(row_item("S", 1'b0));
        stim_rows.push_back(row_item("L", 1'b0));   // doubled last letter
        stim_rows.push_back(row_item("L", 1'b1));
        stim_rows.push_back(row_item("Q", 1'b1));   // odd end padded
        stim_rows.push_back(row_item("X", 1'b0));   // filler doubled with itself
        stim_rows.push_back(row_item("X", 1'b1));
        // Extreme codes in the square, repeated letters, filler 0xFF.
        stim_rows.push_back(row_cfg(REG_ROW0, 40'hFF_FF_FF_FF_FF));
        stim_rows.push_back(row_cfg(REG_ROW1, 40'h00_00_00_00_00));
        stim_rows.push_back(row_cfg(REG_ROW2, 40'h45_44_43_42_41));
        stim_rows.push_back(row_cfg(REG_ROW3, 40'h4A_49_48_47_46));
        stim_rows.push_back(row_cfg(REG_ROW4, 40'h45_44_43_42_41));
        stim_rows.push_back(row_cfg(REG_FILLER, 40'hFF));
        stim_rows.push_back(row_item(8'hFF, 1'b1));
        stim_rows.push_back(row_item("A", 1'b0));
        stim_rows.push_back(row_item("J", 1'b0));
        stim_rows.push_back(row_item("C", 1'b1));
        stim_rows.push_back(row_item(8'h00, 1'b0));
        stim_rows.push_back(row_item("E", 1'b1));

        phase_kind = '{SQ_ALPHABET, SQ_ALPHABET, SQ_FEW_LETTERS,
                       SQ_ANY_BYTES, SQ_ALPHABET, SQ_FEW_LETTERS};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table; registers change only once the block has drained.
        foreach (stim_rows[i])
        begin
            if (stim_rows[i].kind == ROW_CFG)
            begin
                if (i == 0 || stim_rows[i-1].kind != ROW_CFG)
                begin
                    drain_block(SETTLE_WAIT);
                    settings_used++;
                end
                write_reg(stim_rows[i].reg_sel, stim_rows[i].value);
            end
            else
                send_row(stim_rows[i]);
        end

        // Random phases, each under a fresh key square.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain_block(SETTLE_WAIT);
            load_square(phase_kind[ph]);
            steady = (ph == 1);
            prev_char = key_sq[0][0];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 40)
                    hold_req = 1'b1;
                if (ph == 4 && n == 40)
                    drain_block(0);
                pick = $urandom_range(99);
                if (pick < 65)
                    ch = key_sq[$urandom_range(SQ_N - 1)][$urandom_range(SQ_N - 1)];
                else if (pick < 78)
                    ch = prev_char;
                else if (pick < 88)
                    ch = filler;
                else
                    ch = char_t'($urandom_range(255));
                row = row_item(ch, $urandom_range(7) == 0);
                send_row(row);
                prev_char = ch;
            end
            steady = 1'b0;
        end

        // Let every predicted word out, then watch for strays.
        drain_block(4 * SETTLE_WAIT);

        $display("Run covered %0d plaintext words under %0d key-square settings,",
                 items_sent, settings_used);
        $display("with %0d cipher words checked and %0d mismatches.",
                 words_checked, err_count);
        if (err_count == 0)
            $display("digraph_square_cipher_encoder_core verification clean");
        else
            $display("digraph_square_cipher_encoder_core verification failed");
        $finish;
    end

endmodule
